/* sv/tps_pkg.sv */
package tps_pkg;

    // pool sizing and time arithmetic width
    localparam int POOL_SIZE  = 16;
    localparam int TIME_WIDTH = 32;
    localparam int MAX_SLOTS  = 16;
    localparam int NUM_SLOTS  = (POOL_SIZE < MAX_SLOTS) ? POOL_SIZE : MAX_SLOTS;
    localparam int IDX_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    // fixed field widths
    localparam int OP_W      = 2;
    localparam int KIND_W    = 2;
    localparam int IN_TIME_W = 32;
    localparam int TAG_W     = 16;
    localparam int SLOT_W    = 4;
    localparam int SLOT_W1   = SLOT_W + 1;

    // queue depths
    localparam int CMD_DEPTH = 2;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);
    localparam int RES_DEPTH = 2;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    // operation codes
    localparam logic [OP_W-1:0] OP_POLL  = 2'd0;
    localparam logic [OP_W-1:0] OP_AT    = 2'd1;
    localparam logic [OP_W-1:0] OP_EVERY = 2'd2;
    localparam logic [OP_W-1:0] OP_AFTER = 2'd3;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_ASSIGNED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NO_FREE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIRED    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DONE     = 2'd3;

    typedef logic [TIME_WIDTH-1:0] time_t;

    typedef struct packed {
        logic [OP_W-1:0]      operation;
        logic [IN_TIME_W-1:0] current_time;
        logic [IN_TIME_W-1:0] time_value;
        logic [TAG_W-1:0]     handler_tag;
        logic                 use_given_slot;
        logic [SLOT_W-1:0]    given_slot;
    } in_item_t;

    typedef struct packed {
        logic [KIND_W-1:0] result_kind;
        logic [SLOT_W-1:0] slot_index;
        logic [TAG_W-1:0]  handler_tag_out;
        logic              last;
    } res_item_t;

    typedef enum logic [1:0] {
        CMD_POLL,
        CMD_SET_GIVEN,
        CMD_SET_FREE,
        CMD_REJECT
    } cmd_kind_t;

    // classified request handed from the front to the engine
    typedef struct packed {
        cmd_kind_t        kind;
        time_t            now;
        time_t            due;
        time_t            reload;
        logic [TAG_W-1:0] tag;
        logic [IDX_W-1:0] slot;
    } cmd_t;

endpackage

/* sv/tps_front.sv */
module tps_front (
    input  logic              push,
    input  tps_pkg::in_item_t request,
    input  logic              cmd_full,
    output logic              cmd_push,
    output tps_pkg::cmd_t     cmd
);
    import tps_pkg::*;

    time_t now_t;
    time_t value_t;
    time_t sum_t;
    logic  given_ok;

    assign now_t    = TIME_WIDTH'(request.current_time);
    assign value_t  = TIME_WIDTH'(request.time_value);
    assign sum_t    = now_t + value_t;
    assign given_ok = SLOT_W1'({1'b0, request.given_slot}) < SLOT_W1'(NUM_SLOTS);
    assign cmd_push = push && !cmd_full;

    always_comb
    begin
        cmd.now  = now_t;
        cmd.tag  = request.handler_tag;
        cmd.slot = request.given_slot[IDX_W-1:0];

        // due time and reload per operation
        case (request.operation)
            OP_AT:
            begin
                cmd.due    = value_t;
                cmd.reload = '0;
            end
            OP_EVERY:
            begin
                cmd.due    = sum_t;
                cmd.reload = value_t;
            end
            OP_AFTER:
            begin
                cmd.due    = sum_t;
                cmd.reload = '0;
            end
            default:
            begin
                cmd.due    = '0;
                cmd.reload = '0;
            end
        endcase

        if (request.operation == OP_POLL)
        begin
            cmd.kind = CMD_POLL;
        end
        else if (request.use_given_slot)
        begin
            cmd.kind = given_ok ? CMD_SET_GIVEN : CMD_REJECT;
        end
        else
        begin
            cmd.kind = CMD_SET_FREE;
        end
    end

endmodule

/* sv/tps_cmd_fifo.sv */
module tps_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tps_pkg::cmd_t wdata,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output tps_pkg::cmd_t rdata
);
    import tps_pkg::*;

    cmd_t                 mem_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg;
    logic [CMD_PTR_W-1:0] wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg;
    logic [CMD_PTR_W-1:0] rd_ptr_next;
    logic [CMD_CNT_W-1:0] count_reg;
    logic [CMD_CNT_W-1:0] count_next;
    logic                 do_push;
    logic                 do_pop;

    assign full    = count_reg == CMD_CNT_W'(CMD_DEPTH);
    assign empty   = count_reg == '0;
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* sv/tps_engine.sv */
module tps_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_empty,
    input  tps_pkg::cmd_t      cmd_head,
    output logic               cmd_pop,
    input  logic               res_full,
    output logic               res_push,
    output tps_pkg::res_item_t res_data
);
    import tps_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POLL,
        ST_FREE,
        ST_REPLY,
        ST_DONE
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     idx_next;
    cmd_t                 cmd_reg;
    cmd_t                 cmd_next;
    logic [NUM_SLOTS-1:0] valid_reg;
    logic [NUM_SLOTS-1:0] valid_next;
    logic [KIND_W-1:0]    reply_kind_reg;
    logic [KIND_W-1:0]    reply_kind_next;
    logic [IDX_W-1:0]     reply_slot_reg;
    logic [IDX_W-1:0]     reply_slot_next;

    // slot payload, only meaningful where the valid bit is set
    logic [TAG_W-1:0]     tag_reg    [NUM_SLOTS];
    time_t                due_reg    [NUM_SLOTS];
    time_t                reload_reg [NUM_SLOTS];

    logic                 wr_en;
    logic [IDX_W-1:0]     wr_idx;
    logic [TAG_W-1:0]     wr_tag;
    time_t                wr_due;
    time_t                wr_reload;

    logic                 sel_valid;
    logic [TAG_W-1:0]     sel_tag;
    time_t                sel_due;
    time_t                sel_reload;
    logic                 hit;
    logic                 last_idx;

    assign sel_valid  = valid_reg[idx_reg];
    assign sel_tag    = tag_reg[idx_reg];
    assign sel_due    = due_reg[idx_reg];
    assign sel_reload = reload_reg[idx_reg];
    assign hit        = sel_valid && (cmd_reg.now >= sel_due);
    assign last_idx   = idx_reg == IDX_W'(NUM_SLOTS - 1);

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        cmd_next        = cmd_reg;
        valid_next      = valid_reg;
        reply_kind_next = reply_kind_reg;
        reply_slot_next = reply_slot_reg;
        cmd_pop         = 1'b0;
        res_push        = 1'b0;
        res_data        = '0;
        wr_en           = 1'b0;
        wr_idx          = idx_reg;
        wr_tag          = cmd_reg.tag;
        wr_due          = cmd_reg.due;
        wr_reload       = cmd_reg.reload;

        case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd_head;
                    idx_next = '0;
                    case (cmd_head.kind)
                        CMD_POLL:
                        begin
                            state_next = ST_POLL;
                        end
                        CMD_SET_FREE:
                        begin
                            state_next = ST_FREE;
                        end
                        CMD_SET_GIVEN:
                        begin
                            wr_en                     = 1'b1;
                            wr_idx                    = cmd_head.slot;
                            wr_tag                    = cmd_head.tag;
                            wr_due                    = cmd_head.due;
                            wr_reload                 = cmd_head.reload;
                            valid_next[cmd_head.slot] = 1'b1;
                            reply_kind_next           = KIND_ASSIGNED;
                            reply_slot_next           = cmd_head.slot;
                            state_next                = ST_REPLY;
                        end
                        default:
                        begin
                            reply_kind_next = KIND_NO_FREE;
                            reply_slot_next = '0;
                            state_next      = ST_REPLY;
                        end
                    endcase
                end
            end

            ST_POLL:
            begin
                if (!hit || !res_full)
                begin
                    if (hit)
                    begin
                        res_push                 = 1'b1;
                        res_data.result_kind     = KIND_FIRED;
                        res_data.slot_index      = SLOT_W'(idx_reg);
                        res_data.handler_tag_out = sel_tag;
                        res_data.last            = 1'b0;
                        if (sel_reload != '0)
                        begin
                            wr_en     = 1'b1;
                            wr_tag    = sel_tag;
                            wr_due    = sel_due + sel_reload;
                            wr_reload = sel_reload;
                        end
                        else
                        begin
                            valid_next[idx_reg] = 1'b0;
                        end
                    end
                    if (last_idx)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            ST_FREE:
            begin
                if (!sel_valid)
                begin
                    wr_en               = 1'b1;
                    valid_next[idx_reg] = 1'b1;
                    reply_kind_next     = KIND_ASSIGNED;
                    reply_slot_next     = idx_reg;
                    state_next          = ST_REPLY;
                end
                else if (last_idx)
                begin
                    reply_kind_next = KIND_NO_FREE;
                    reply_slot_next = '0;
                    state_next      = ST_REPLY;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            ST_REPLY:
            begin
                if (!res_full)
                begin
                    res_push                 = 1'b1;
                    res_data.result_kind     = reply_kind_reg;
                    res_data.slot_index      = SLOT_W'(reply_slot_reg);
                    res_data.handler_tag_out = cmd_reg.tag;
                    res_data.last            = 1'b1;
                    state_next               = ST_IDLE;
                end
            end

            ST_DONE:
            begin
                if (!res_full)
                begin
                    res_push             = 1'b1;
                    res_data.result_kind = KIND_DONE;
                    res_data.last        = 1'b1;
                    state_next           = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            cmd_reg        <= '0;
            valid_reg      <= '0;
            reply_kind_reg <= KIND_ASSIGNED;
            reply_slot_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            cmd_reg        <= cmd_next;
            valid_reg      <= valid_next;
            reply_kind_reg <= reply_kind_next;
            reply_slot_reg <= reply_slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tag_reg[wr_idx]    <= wr_tag;
            due_reg[wr_idx]    <= wr_due;
            reload_reg[wr_idx] <= wr_reload;
        end
    end

endmodule

/* sv/tps_res_fifo.sv */
module tps_res_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  tps_pkg::res_item_t wdata,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    output tps_pkg::res_item_t rdata
);
    import tps_pkg::*;

    res_item_t            mem_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0] wr_ptr_reg;
    logic [RES_PTR_W-1:0] wr_ptr_next;
    logic [RES_PTR_W-1:0] rd_ptr_reg;
    logic [RES_PTR_W-1:0] rd_ptr_next;
    logic [RES_CNT_W-1:0] count_reg;
    logic [RES_CNT_W-1:0] count_next;
    logic                 do_push;
    logic                 do_pop;

    assign full    = count_reg == RES_CNT_W'(RES_DEPTH);
    assign empty   = count_reg == '0;
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == RES_PTR_W'(RES_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == RES_PTR_W'(RES_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* sv/timer_pool_scheduler.sv */
// a schedule into a given slot is written as the engine takes it from the command queue, then replied
// a free-slot schedule searches up to NUM_SLOTS slots in index order for the first free one
// a poll walks one slot per cycle, holding on a hit while the result queue is full; poll-finished follows the last slot
// the engine takes no new item until the current one has pushed its last result
// reset (rst_n low, asynchronous): every slot freed, both queues emptied
module timer_pool_scheduler (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  tps_pkg::in_item_t  request,
    output logic               empty,
    input  logic               pop,
    output tps_pkg::res_item_t result
);
    import tps_pkg::*;

    // front to command queue
    logic      front_push;
    cmd_t      front_cmd;

    // command queue to engine
    logic      cmd_empty;
    logic      cmd_pop;
    cmd_t      cmd_head;

    // engine to result queue
    logic      res_full;
    logic      res_push;
    res_item_t res_data;

    // front: decode the operation, compute due time and reload, check the given slot
    tps_front u_front (
        .push     (push),
        .request  (request),
        .cmd_full (full),
        .cmd_push (front_push),
        .cmd      (front_cmd)
    );

    // short queue decouples intake from the slot walk
    tps_cmd_fifo u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_push),
        .wdata (front_cmd),
        .full  (full),
        .pop   (cmd_pop),
        .empty (cmd_empty),
        .rdata (cmd_head)
    );

    // engine: owns the slot table, walks slots for polls and free-slot search,
    // stalls on a full result queue without losing its place
    tps_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_head  (cmd_head),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_data)
    );

    // result queue, head drives the result ports
    tps_res_fifo u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_data),
        .full  (res_full),
        .pop   (pop),
        .empty (empty),
        .rdata (result)
    );

endmodule

/* sv/tps_checker.sv */
module tps_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               push,
    input logic               full,
    input tps_pkg::in_item_t  request,
    input logic               empty,
    input logic               pop,
    input tps_pkg::res_item_t result
);
    import tps_pkg::*;

    // queues stay empty while reset is held
    a_reset_empty: assert property (@(posedge clk) !rst_n && $past(!rst_n) |-> empty && !full)
        else $error("queues not empty during reset");

    // a waiting result holds until taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result))
        else $error("waiting result changed");

    // only fired results leave the item open
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> result.last == (result.result_kind != KIND_FIRED))
        else $error("last flag does not match result kind");

    // poll-finished and no-free results carry slot zero, poll-finished carries no tag
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && (result.result_kind == KIND_DONE || result.result_kind == KIND_NO_FREE)
        |-> result.slot_index == '0
            && (result.result_kind != KIND_DONE || result.handler_tag_out == '0))
        else $error("unexpected slot or tag on result");

endmodule

bind timer_pool_scheduler tps_checker u_tps_checker (.*);

/* tb/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tps_pkg::*;

    // cycles without any handshake before the run is declared hung
    localparam int STALL_LIMIT = 3000;
    // random requests per idling phase
    localparam int PHASE_REQS = 113;

    logic      clk;
    logic      rst_n;
    logic      push;
    logic      full;
    in_item_t  request;
    logic      empty;
    logic      pop;
    res_item_t result;

    timer_pool_scheduler u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .request (request),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    // one row of the directed table: a request, how often to send it, and
    // optionally the single result typed in by hand
    typedef struct {
        in_item_t  req;
        int        reps;
        bit        typed;
        res_item_t want;
    } dir_row_t;

    // shadow copy of the timer pool
    logic                 slot_live   [NUM_SLOTS];
    logic [TAG_W-1:0]     slot_tag    [NUM_SLOTS];
    time_t                slot_due    [NUM_SLOTS];
    time_t                slot_reload [NUM_SLOTS];

    res_item_t step_results    [$];   // results of the request just modeled
    res_item_t pending_results [$];   // results still owed by the block
    dir_row_t  dir_rows        [$];

    int    send_idle_pct;
    int    recv_idle_pct;
    int    fail_count;
    int    idle_cycles;
    time_t tick;                      // running tick count for well-formed traffic

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // pool model: fills step_results with what one request must produce
    // ------------------------------------------------------------------
    function automatic void model_request(input in_item_t r);
        int    pick;
        time_t now;
        time_t tv;
        time_t due;
        time_t rel;
        step_results.delete();
        now = time_t'(r.current_time);
        tv  = time_t'(r.time_value);
        if (r.operation == OP_POLL)
        begin
            // scan in index order, fire everything due at or before now
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                if (slot_live[i] && now >= slot_due[i])
                begin
                    step_results.push_back('{KIND_FIRED, SLOT_W'(i), slot_tag[i], 1'b0});
                    if (slot_reload[i] != '0)
                    begin
                        // periodic: advance by one reload, wrapping
                        slot_due[i] = slot_due[i] + slot_reload[i];
                    end
                    else
                    begin
                        // one-shot or zero period: slot goes back to the free list
                        slot_live[i]   = 1'b0;
                        slot_tag[i]    = '0;
                        slot_due[i]    = '0;
                        slot_reload[i] = '0;
                    end
                end
            end
            step_results.push_back('{KIND_DONE, SLOT_W'(0), TAG_W'(0), 1'b1});
        end
        else
        begin
            pick = -1;
            if (r.use_given_slot)
            begin
                // given slot is overwritten whatever it holds, if it exists
                if (int'(r.given_slot) < NUM_SLOTS)
                    pick = int'(r.given_slot);
            end
            else
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (pick < 0 && !slot_live[i])
                        pick = i;
                end
            end
            if (pick < 0)
            begin
                step_results.push_back('{KIND_NO_FREE, SLOT_W'(0), r.handler_tag, 1'b1});
            end
            else
            begin
                case (r.operation)
                    OP_AT:
                    begin
                        due = tv;
                        rel = '0;
                    end
                    OP_EVERY:
                    begin
                        due = now + tv;
                        rel = tv;
                    end
                    default:
                    begin
                        due = now + tv;
                        rel = '0;
                    end
                endcase
                slot_live[pick]   = 1'b1;
                slot_tag[pick]    = r.handler_tag;
                slot_due[pick]    = due;
                slot_reload[pick] = rel;
                step_results.push_back('{KIND_ASSIGNED, SLOT_W'(pick), r.handler_tag, 1'b1});
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // random request: mostly a plausible timeline, some pure noise
    // ------------------------------------------------------------------
    function automatic in_item_t random_request();
        in_item_t r;
        int       roll;
        roll = $urandom_range(99);
        if (roll < 10)
        begin
            // noise: every field across its whole range
            r.operation      = OP_W'($urandom);
            r.current_time   = IN_TIME_W'($urandom);
            r.time_value     = IN_TIME_W'($urandom);
            r.handler_tag    = TAG_W'($urandom);
            r.use_given_slot = 1'($urandom);
            r.given_slot     = SLOT_W'($urandom);
        end
        else
        begin
            // tick moves forward; now and then it jumps close to the wrap point
            if (roll < 13)
                tick = 32'hFFFF_FF80 + 32'($urandom_range(0, 64));
            else
                tick = tick + 32'($urandom_range(0, 40));
            r.current_time = tick;
            roll = $urandom_range(99);
            if (roll < 40)
                r.operation = OP_POLL;
            else if (roll < 65)
                r.operation = OP_AT;
            else if (roll < 78)
                r.operation = OP_EVERY;
            else
                r.operation = OP_AFTER;
            case (r.operation)
                OP_AT:    r.time_value = tick + 32'($urandom_range(0, 150));
                OP_EVERY: r.time_value = 32'($urandom_range(0, 50));
                default:  r.time_value = 32'($urandom_range(0, 150));
            endcase
            if ($urandom_range(99) < 5)
                r.time_value = IN_TIME_W'($urandom);
            r.handler_tag    = TAG_W'($urandom);
            r.use_given_slot = ($urandom_range(99) < 25);
            r.given_slot     = SLOT_W'($urandom);
        end
        return r;
    endfunction

    task automatic add_row(input logic [OP_W-1:0] op, input logic [31:0] now,
                           input logic [31:0] tv, input logic [TAG_W-1:0] tag,
                           input logic use_given, input logic [SLOT_W-1:0] slot,
                           input int reps, input bit typed,
                           input logic [KIND_W-1:0] w_kind,
                           input logic [SLOT_W-1:0] w_slot,
                           input logic [TAG_W-1:0] w_tag);
        dir_row_t row;
        row.req   = '{op, now, tv, tag, use_given, slot};
        row.reps  = reps;
        row.typed = typed;
        row.want  = '{w_kind, w_slot, w_tag, 1'b1};
        dir_rows.push_back(row);
    endtask

    // ------------------------------------------------------------------
    // request side: random gap, raise push, hold until accepted
    // ------------------------------------------------------------------
    task automatic send_req(input in_item_t r, input bit typed, input res_item_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push = 1'b0;
            @(negedge clk);
        end
        push    = 1'b1;
        request = r;
        @(posedge clk);
        while (full)
            @(posedge clk);
        // accepted at this edge: book what it owes
        model_request(r);
        if (typed)
            pending_results.push_back(want);
        else
            foreach (step_results[k])
                pending_results.push_back(step_results[k]);
        @(negedge clk);
    endtask

    // hold the request side until the block has delivered everything owed
    task automatic pause_until_drained();
        push = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // result side: pop at random, compare at the rising edge
    // ------------------------------------------------------------------
    initial
    begin
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            pop = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        res_item_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result kind=%0d slot=%0d tag=%h last=%b",
                         $time, result.result_kind, result.slot_index,
                         result.handler_tag_out, result.last);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result !== want)
                begin
                    $display("%0t: mismatch exp kind=%0d slot=%0d tag=%h last=%b",
                             $time, want.result_kind, want.slot_index,
                             want.handler_tag_out, want.last);
                    $display("%0t:          got kind=%0d slot=%0d tag=%h last=%b",
                             $time, result.result_kind, result.slot_index,
                             result.handler_tag_out, result.last);
                    fail_count++;
                end
            end
        end
    end

    // watchdog: any accepted request or result restarts the count
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        push          = 1'b0;
        request       = '0;
        fail_count    = 0;
        tick          = '0;
        send_idle_pct = 34;
        recv_idle_pct = 78;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            slot_live[i]   = 1'b0;
            slot_tag[i]    = '0;
            slot_due[i]    = '0;
            slot_reload[i] = '0;
        end

        // directed table: op, now, value, tag, given?, slot, reps, typed, expected
        // poll on an empty pool only finishes
        add_row(OP_POLL,  32'd0,         32'd0,         16'h0000, 1'b0, 4'd0,  1, 1,
                KIND_DONE,     4'd0,  16'h0000);
        // first free slot is slot 0, then 1, 2, 3
        add_row(OP_AT,    32'd0,         32'd0,         16'hFFFF, 1'b0, 4'd0,  1, 1,
                KIND_ASSIGNED, 4'd0,  16'hFFFF);
        // largest period from the top of time: due wraps
        add_row(OP_EVERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000, 1'b0, 4'd0,  1, 1,
                KIND_ASSIGNED, 4'd1,  16'h0000);
        // delay crossing the wrap point
        add_row(OP_AFTER, 32'hFFFF_FFF0, 32'h0000_0020, 16'h1234, 1'b0, 4'd0,  1, 1,
                KIND_ASSIGNED, 4'd2,  16'h1234);
        // zero period acts as a one-shot
        add_row(OP_EVERY, 32'd100,       32'd0,         16'hA5A5, 1'b0, 4'd0,  1, 1,
                KIND_ASSIGNED, 4'd3,  16'hA5A5);
        // highest given slot
        add_row(OP_AT,    32'd0,         32'hFFFF_FFFF, 16'h5A5A, 1'b1, 4'd15, 1, 1,
                KIND_ASSIGNED, 4'd15, 16'h5A5A);
        // given slot already occupied is overwritten
        add_row(OP_AFTER, 32'd5,         32'd10,        16'h0F0F, 1'b1, 4'd0,  1, 1,
                KIND_ASSIGNED, 4'd0,  16'h0F0F);
        // polls: ignored fields set, the zero-period slot, a repeat, top of time
        add_row(OP_POLL,  32'd15,        32'hFFFF_FFFF, 16'hFFFF, 1'b1, 4'd15, 1, 0,
                KIND_DONE,     4'd0,  16'h0000);
        add_row(OP_POLL,  32'd100,       32'd0,         16'h0000, 1'b0, 4'd0,  1, 0,
                KIND_DONE,     4'd0,  16'h0000);
        add_row(OP_POLL,  32'd100,       32'd0,         16'h0000, 1'b0, 4'd0,  1, 0,
                KIND_DONE,     4'd0,  16'h0000);
        add_row(OP_POLL,  32'hFFFF_FFFF, 32'd0,         16'h0000, 1'b0, 4'd0,  1, 0,
                KIND_DONE,     4'd0,  16'h0000);
        // fill the rest of the pool
        add_row(OP_AT,    32'd0,         32'hFFFF_FFFF, 16'hC3C3, 1'b0, 4'd0, 15, 0,
                KIND_DONE,     4'd0,  16'h0000);
        // pool full: no free slot carries the requested tag
        add_row(OP_AFTER, 32'd0,         32'd1,         16'hBEEF, 1'b0, 4'd0,  1, 1,
                KIND_NO_FREE,  4'd0,  16'hBEEF);
        // given slot still works on a full pool
        add_row(OP_EVERY, 32'd0,         32'd1,         16'h7777, 1'b1, 4'd7,  1, 1,
                KIND_ASSIGNED, 4'd7,  16'h7777);
        // every slot due at once gives the longest result burst
        add_row(OP_POLL,  32'd2,         32'd0,         16'h0000, 1'b0, 4'd0,  1, 0,
                KIND_DONE,     4'd0,  16'h0000);
        add_row(OP_POLL,  32'hFFFF_FFFF, 32'd0,         16'h0000, 1'b0, 4'd0,  1, 0,
                KIND_DONE,     4'd0,  16'h0000);
        add_row(OP_POLL,  32'd0,         32'd0,         16'h0000, 1'b1, 4'd3,  1, 0,
                KIND_DONE,     4'd0,  16'h0000);

        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[n])
            repeat (dir_rows[n].reps)
                send_req(dir_rows[n].req, dir_rows[n].typed, dir_rows[n].want);

        // hold-off: let the block drain completely before random traffic
        pause_until_drained();

        // random phases: slow sender / slow receiver, swapped, then no idling
        for (int p = 0; p < 3; p++)
        begin
            case (p)
                0:
                begin
                    send_idle_pct = 34;
                    recv_idle_pct = 78;
                end
                1:
                begin
                    send_idle_pct = 78;
                    recv_idle_pct = 34;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int k = 0; k < PHASE_REQS; k++)
                send_req(random_request(), 1'b0, '0);
            pause_until_drained();
        end

        // tail: give the block time to show anything extra
        repeat (NUM_SLOTS + 8) @(negedge clk);

        if (fail_count == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* filelist.f */
sv/tps_pkg.sv
sv/tps_front.sv
sv/tps_cmd_fifo.sv
sv/tps_engine.sv
sv/tps_res_fifo.sv
sv/timer_pool_scheduler.sv
sv/tps_checker.sv
tb/tb.sv
